// ===== hw/rtl/bbd_pkg.sv =====
// Shared types and constants for the button bank debouncer.
package bbd_pkg;

  localparam int NUM_BUTTONS = 15;
  localparam int IGN_BIT     = NUM_BUTTONS - 1;
  localparam int CNT_W       = 8;
  localparam int CFG_DATA_W  = (NUM_BUTTONS > CNT_W) ? NUM_BUTTONS : CNT_W;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CNT_W-1:0]       CNT_MAX            = '1;
  localparam logic [CNT_W-1:0]       GUARD_RESET        = CNT_W'(3);
  localparam logic [NUM_BUTTONS-1:0] ACTIVE_LOW_RESET   = NUM_BUTTONS'(30976);

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LOW_MASK = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    SEL_OFF = 2'd0,
    SEL_ONE = 2'd1,
    SEL_TWO = 2'd2
  } sel_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] button_pins;
    logic                   arm_pin;
    logic                   three_way_pin;
    logic                   select_one_pin;
    logic                   select_two_pin;
  } sample_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] button_states;
    logic                   arm_state;
    logic                   three_way_state;
    logic [1:0]             selector_state;
  } result_t;

  // stage control from the top level into the bank
  typedef struct packed {
    logic take;     // request accepted into the sample register
    logic advance;  // sample register moves into the result register
  } stage_ctrl_t;

endpackage

// ===== hw/rtl/bbd_button.sv =====
// One counter debouncer cell: hold counter plus pressed flag.
module bbd_button (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       active,
  input  logic [bbd_pkg::CNT_W-1:0]  threshold,
  output logic                       pressed_next
);

  logic [bbd_pkg::CNT_W-1:0] count;
  logic [bbd_pkg::CNT_W-1:0] count_next;
  logic                      pressed;

  always_comb begin
    count_next   = count;
    pressed_next = pressed;
    priority if (!active) begin
      count_next   = '0;
      pressed_next = 1'b0;
    end else if (count > threshold) begin
      count_next   = '0;
      pressed_next = 1'b1;
    end else if (count != bbd_pkg::CNT_MAX) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pressed <= 1'b0;
    end else if (advance) begin
      count   <= count_next;
      pressed <= pressed_next;
    end
  end

endmodule

// ===== hw/rtl/bbd_bank.sv =====
// Sample register, debouncer cells and selector decode.
module bbd_bank (
  input  logic                             clk,
  input  logic                             rst,
  input  bbd_pkg::stage_ctrl_t             ctrl,
  input  bbd_pkg::sample_t                 sample,
  input  logic [bbd_pkg::CNT_W-1:0]        hold_limit,
  input  logic [bbd_pkg::NUM_BUTTONS-1:0]  active_low_mask,
  output logic                             smp_valid,
  output bbd_pkg::result_t                 result_next
);

  bbd_pkg::sample_t              smp;
  bbd_pkg::sel_t                 selector;
  bbd_pkg::sel_t                 selector_next;
  logic [bbd_pkg::NUM_BUTTONS-1:0] active;
  logic [bbd_pkg::NUM_BUTTONS-1:0] pressed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (ctrl.take) begin
      smp_valid <= 1'b1;
    end else if (ctrl.advance) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      smp <= sample;
    end
  end

  // polarity fix, ignition gated by the arm lever
  always_comb begin
    active = smp.button_pins ^ active_low_mask;
    active[bbd_pkg::IGN_BIT] = active[bbd_pkg::IGN_BIT] & smp.arm_pin;
  end

  for (genvar i = 0; i < bbd_pkg::NUM_BUTTONS; i++) begin : g_btn
    bbd_button u_button (
      .clk          (clk),
      .rst          (rst),
      .advance      (ctrl.advance),
      .active       (active[i]),
      .threshold    (hold_limit),
      .pressed_next (pressed_next[i])
    );
  end

  always_comb begin
    unique case ({smp.select_one_pin, smp.select_two_pin})
      2'b11:   selector_next = selector;  // both high: hold
      2'b10:   selector_next = bbd_pkg::SEL_ONE;
      2'b01:   selector_next = bbd_pkg::SEL_TWO;
      default: selector_next = bbd_pkg::SEL_OFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selector <= bbd_pkg::SEL_OFF;
    end else if (ctrl.advance) begin
      selector <= selector_next;
    end
  end

  always_comb begin
    result_next.button_states   = pressed_next;
    result_next.arm_state       = smp.arm_pin;
    result_next.three_way_state = smp.three_way_pin;
    result_next.selector_state  = selector_next;
  end

endmodule

// ===== hw/rtl/button_bank_debouncer.sv =====
// Top level of the button bank debouncer: config registers, handshake, result register.
//
// Debounces a bank of push buttons sampled once per tick. Each request carries the
// raw pin levels; every button pin is XORed with active_low_mask so that a set bit
// means pressed, and the ignition button (top bit) only counts while arm_pin is high.
// A button's pressed flag rises once its hold counter exceeds hold_limit (register 0)
// and stays up while held; a released sample clears flag and counter at once. Levers
// are passed through, the selector is decoded to off / one / two, and both selector
// pins high keeps the last selector value. One result comes out per request, in order.
// Throughput is one request per clock while result_stall is low: a request is held in the
// sample register, the cell update runs in front of the result register, and result_valid
// rises as the result register loads. A held result_stall backs up into the sample
// register and then into sample_stall. Write config only while idle.
module button_bank_debouncer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  bbd_pkg::sample_t                    sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bbd_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [bbd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [bbd_pkg::CNT_W-1:0]       hold_limit;
  logic [bbd_pkg::NUM_BUTTONS-1:0] active_low_mask;
  bbd_pkg::stage_ctrl_t            ctrl;
  bbd_pkg::result_t                result_next;
  logic                            smp_valid;
  logic                            out_free;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit      <= bbd_pkg::GUARD_RESET;
      active_low_mask <= bbd_pkg::ACTIVE_LOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbd_pkg::REG_HOLD_LIMIT:      hold_limit <= cfg_data[bbd_pkg::CNT_W-1:0];
        bbd_pkg::REG_ACTIVE_LOW_MASK: active_low_mask <= cfg_data[bbd_pkg::NUM_BUTTONS-1:0];
        default: ;
      endcase
    end
  end

  // result register can load when empty or being drained this cycle
  assign out_free     = !result_valid || !result_stall;
  assign ctrl.advance = smp_valid && out_free;
  assign sample_stall = smp_valid && !ctrl.advance;
  assign ctrl.take    = sample_valid && !sample_stall;

  bbd_bank u_bank (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .sample          (sample),
    .hold_limit      (hold_limit),
    .active_low_mask (active_low_mask),
    .smp_valid       (smp_valid),
    .result_next     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      result <= result_next;
    end
  end

  // a stage that advances always lands a result next cycle
  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    ctrl.advance |=> result_valid)
    else $error("advanced request did not reach result register");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !ctrl.advance)
    else $error("result register overwritten while stalled");

  // ignition never reads pressed with the arm lever off
  a_ign_gated: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.arm_state) |-> !result.button_states[bbd_pkg::IGN_BIT])
    else $error("ignition pressed while disarmed");

  // selector decode never yields the unused code
  a_sel_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.selector_state != 2'd3))
    else $error("illegal selector code");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

// ===== tb/button_bank_debouncer_checker.sv =====
// Checker for the button bank debouncer: tracks config, predicts each result, compares.
`timescale 1ns / 100ps

module button_bank_debouncer_checker import bbd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   sample_stall,
  input  sample_t                sample,
  input  logic                   result_valid,
  input  logic                   result_stall,
  input  result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     outstanding
);

  logic [CNT_W-1:0]       guard;
  logic [NUM_BUTTONS-1:0] low_mask;
  logic [CNT_W-1:0]       hold_cnt [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] pressed;
  sel_t                   sel_held;
  result_t                debounced_q [$];
  int                     err_count = 0;

  // one tick of the whole bank; updates counters, flags and selector
  function automatic result_t debounce_tick(input sample_t s);
    logic [NUM_BUTTONS-1:0] active;
    result_t                r;
    active = s.button_pins ^ low_mask;
    active[IGN_BIT] = active[IGN_BIT] & s.arm_pin;
    case ({s.select_one_pin, s.select_two_pin})
      2'b10:   sel_held = SEL_ONE;
      2'b01:   sel_held = SEL_TWO;
      2'b00:   sel_held = SEL_OFF;
      default: ; // both pins high: keep
    endcase
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (!active[b]) begin
        hold_cnt[b] = '0;
        pressed[b]  = 1'b0;
      end else if (hold_cnt[b] > guard) begin
        hold_cnt[b] = '0;
        pressed[b]  = 1'b1;
      end else if (hold_cnt[b] != CNT_MAX) begin
        hold_cnt[b] = hold_cnt[b] + 1'b1;
      end
    end
    r.button_states   = pressed;
    r.arm_state       = s.arm_pin;
    r.three_way_state = s.three_way_pin;
    r.selector_state  = sel_held;
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
    err_count++;
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      guard    = GUARD_RESET;
      low_mask = ACTIVE_LOW_RESET;
      for (int b = 0; b < NUM_BUTTONS; b++) hold_cnt[b] = '0;
      pressed  = '0;
      sel_held = SEL_OFF;
      debounced_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HOLD_LIMIT) guard = cfg_data[CNT_W-1:0];
        else if (cfg_index == REG_ACTIVE_LOW_MASK) low_mask = cfg_data[NUM_BUTTONS-1:0];
      end
      // a result is never out while its own request is being taken, so pop before push
      if (result_valid && !result_stall) begin
        if (debounced_q.size() == 0) begin
          err_count++;
          $display("%0t: result with none pending, expected nothing got %h", $time, result);
        end else begin
          want = debounced_q.pop_front();
          if (result.button_states !== want.button_states)
            flag_field("button_states", 32'(want.button_states),
                       32'(result.button_states));
          if (result.arm_state !== want.arm_state)
            flag_field("arm_state", 32'(want.arm_state), 32'(result.arm_state));
          if (result.three_way_state !== want.three_way_state)
            flag_field("three_way_state", 32'(want.three_way_state),
                       32'(result.three_way_state));
          if (result.selector_state !== want.selector_state)
            flag_field("selector_state", 32'(want.selector_state),
                       32'(result.selector_state));
        end
      end
      if (sample_valid && !sample_stall) debounced_q.push_back(debounce_tick(sample));
    end
    errors      <= err_count;
    outstanding <= debounced_q.size();
  end

endmodule

// ===== tb/button_bank_debouncer_tb.sv =====
// Testbench top for the button bank debouncer: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps

module button_bank_debouncer_tb;
  import bbd_pkg::*;

  localparam int          SAMPLE_W    = $bits(sample_t);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_OFF    = 400;   // long receiver hold-off, in cycles

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  sample_t                sample       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result;
  logic                   cfg_we       = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = REG_HOLD_LIMIT;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  int                     fail_count;
  int                     in_flight;

  // stimulus shaping state (not prediction)
  int                     send_pct      = 0;
  int                     stall_pct     = 0;
  int unsigned            hold_off_reqs = 0;
  logic [NUM_BUTTONS-1:0] held_level;     // intended active level per button
  logic                   arm_level;
  logic [NUM_BUTTONS-1:0] cur_mask      = ACTIVE_LOW_RESET;
  int unsigned            cycle_count   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_bank_debouncer DUT (.*);

  button_bank_debouncer_checker checker_i (
    .*,
    .errors     (fail_count),
    .outstanding(in_flight)
  );

  // run-length guard
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("button_bank_debouncer_tb: errors");
    $finish;
  end

  // Receiver: random stall per cycle, or a long hold-off when one is requested.
  // The hold-off length is counted here so the sender keeps offering requests
  // meanwhile and the block backs up into sample_stall.
  initial begin
    int unsigned seen;
    int          left;
    seen = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_reqs != seen) begin
        seen = hold_off_reqs;
        left = HOLD_OFF;
      end
      if (left > 0) begin
        left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  stall_pct = 0;  end
      IDLE_SEND: begin send_pct = 48; stall_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  stall_pct = 48; end
      default:   begin send_pct = 16; stall_pct = 16; end
    endcase
  endtask

  // Offer one request and hold it until accepted. Valid stays high into the
  // next request unless a random gap drops it here.
  task automatic send_sample(input sample_t s);
    sample       <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    if ($urandom_range(99) < send_pct) begin
      sample_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
  endtask

  // Block until every predicted result has been taken. in_flight is a registered
  // copy in the checker, hence an edge comes before the first test.
  task automatic wait_idle();
    do @(posedge clk); while (in_flight != 0);
  endtask

  // Both registers, back to back; spare high bits of the threshold write are
  // junk that the block must drop.
  task automatic set_config(input logic [CNT_W-1:0] thr, input logic [NUM_BUTTONS-1:0] mask);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[CNT_W-1:0] = thr;
    cfg_we    <= 1'b1;
    cfg_index <= REG_HOLD_LIMIT;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_ACTIVE_LOW_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mask   = mask;
  endtask

  // One phase of random requests. Buttons follow slowly changing held levels
  // (flip_div sets how rarely a level flips) so counters reach the threshold;
  // noisy phases mix in fully random requests and single-pin glitches.
  task automatic run_phase(input logic [CNT_W-1:0] thr, input logic [NUM_BUTTONS-1:0] mask,
                           input idle_mode_t mode, input int n, input int flip_div,
                           input bit noisy, input bit squeeze);
    sample_t s;
    int      g;
    wait_idle();
    set_config(thr, mask);
    set_idle(mode);
    if (squeeze) hold_off_reqs++;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        // drain completely mid-phase
        sample_valid <= 1'b0;
        wait_idle();
      end
      if (noisy && $urandom_range(9) == 0) begin
        s = sample_t'(SAMPLE_W'($urandom));
      end else begin
        for (int b = 0; b < NUM_BUTTONS; b++)
          if ($urandom_range(flip_div - 1) == 0) held_level[b] = ~held_level[b];
        if ($urandom_range(flip_div * 2 - 1) == 0) arm_level = ~arm_level;
        s.button_pins   = held_level ^ cur_mask;
        s.arm_pin       = arm_level;
        s.three_way_pin = 1'($urandom);
        {s.select_one_pin, s.select_two_pin} = 2'($urandom);
        if (noisy && $urandom_range(29) == 0) begin
          g = $urandom_range(NUM_BUTTONS - 1);
          s.button_pins[g] = ~s.button_pins[g];
        end
      end
      send_sample(s);
    end
    sample_valid <= 1'b0;
  endtask

  initial begin
    held_level = NUM_BUTTONS'($urandom);
    arm_level  = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed, at reset config (threshold 3, mask 0x7900)
    set_idle(IDLE_NONE);
    send_sample('{15'h0000, 1'b0, 1'b0, 1'b0, 1'b0});
    send_sample('{15'h7FFF, 1'b1, 1'b1, 1'b1, 1'b1});  // both selector pins: stay off
    send_sample('{15'h0000, 1'b1, 1'b0, 1'b1, 1'b0});  // position one
    send_sample('{15'h7FFF, 1'b0, 1'b1, 1'b1, 1'b1});  // keep one
    send_sample('{15'h0000, 1'b1, 1'b1, 1'b0, 1'b1});  // position two
    send_sample('{15'h7FFF, 1'b1, 1'b0, 1'b1, 1'b1});  // keep two
    send_sample('{15'h0000, 1'b0, 1'b0, 1'b0, 1'b0});  // off
    // every button active, arm on: flags rise once each count passes the
    // threshold and stay
    for (int k = 0; k < 8; k++)
      send_sample('{15'h06FF, 1'b1, k[0], k[1], k[2]});
    // arm off drops ignition only
    send_sample('{15'h06FF, 1'b0, 1'b1, 1'b0, 1'b0});
    send_sample('{15'h06FF, 1'b0, 1'b0, 1'b1, 1'b1});
    // release everything
    send_sample('{15'h7900, 1'b1, 1'b0, 1'b0, 1'b0});
    send_sample('{15'h5555, 1'b1, 1'b1, 1'b0, 1'b1});
    send_sample('{15'h2AAA, 1'b0, 1'b0, 1'b1, 1'b0});
    sample_valid <= 1'b0;

    // random phases over several settings, extremes included
    run_phase(8'd3,   ACTIVE_LOW_RESET,         IDLE_NONE, 130, 12,   1'b1, 1'b0);
    run_phase(8'd0,   15'h0000,                 IDLE_SEND, 130, 6,    1'b1, 1'b0);
    run_phase(8'd1,   15'h7FFF,                 IDLE_RECV, 130, 8,    1'b1, 1'b0);
    run_phase(8'd7,   NUM_BUTTONS'($urandom),   IDLE_BOTH, 130, 20,   1'b1, 1'b0);
    // long holds so counters get past threshold 254; at 255 the counter saturates, no flag rises
    run_phase(8'd254, NUM_BUTTONS'($urandom),   IDLE_NONE, 300, 1000, 1'b0, 1'b0);
    run_phase(8'd255, NUM_BUTTONS'($urandom),   IDLE_SEND, 300, 1000, 1'b0, 1'b0);
    run_phase(CNT_W'($urandom_range(15)), NUM_BUTTONS'($urandom),
              IDLE_RECV, 130, 10, 1'b1, 1'b0);
    // receiver holds off at the start while the sender keeps pushing
    run_phase(8'd2,   ACTIVE_LOW_RESET,         IDLE_BOTH, 130, 10,   1'b1, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("button_bank_debouncer_tb: clean");
    end else begin
      $display("button_bank_debouncer_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_button.sv
hw/rtl/bbd_bank.sv
hw/rtl/button_bank_debouncer.sv
tb/button_bank_debouncer_checker.sv
tb/button_bank_debouncer_tb.sv
